>>> rtl/enat_pkg.sv
// Shared types and codes for the expiring node address table.
`default_nettype none
package enat_pkg;

  // Field widths that the item formats fix.
  localparam int KEY_W  = 160;
  localparam int TIME_W = 32;
  localparam int LIFE_W = 16;
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 64;

  // Item kinds.
  localparam logic [1:0] KIND_PUT    = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_NEW     = 3'd0;
  localparam logic [2:0] ST_REFRESH = 3'd1;
  localparam logic [2:0] ST_SELF    = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_HIT     = 3'd4;
  localparam logic [2:0] ST_MISS    = 3'd5;
  localparam logic [2:0] ST_EXPIRED = 3'd6;

  // Configuration register indexes.
  localparam logic [CFG_IW-1:0] REG_OWN_TOP  = 2'd0;
  localparam logic [CFG_IW-1:0] REG_OWN_MID  = 2'd1;
  localparam logic [CFG_IW-1:0] REG_OWN_LOW  = 2'd2;
  localparam logic [CFG_IW-1:0] REG_LIFETIME = 2'd3;

  localparam logic [LIFE_W-1:0] LIFETIME_RESET = 16'd900;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] key_top;
    logic [63:0] key_mid;
    logic [63:0] key_low;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [15:0] port_in;
    logic [31:0] now_seconds;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] found_address_high;
    logic [63:0] found_address_low;
    logic [15:0] found_port;
    logic [6:0]  removed_count;
    logic [6:0]  occupancy;
  } out_item_t;

  // One table slot as it sits in the memory.
  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [63:0]       address_high;
    logic [63:0]       address_low;
    logic [15:0]       port;
    logic [TIME_W-1:0] expiry;
  } entry_t;

  // Flags from the shared slot compare unit.
  typedef struct packed {
    logic match;
    logic free;
    logic expired;
  } cmp_flags_t;

endpackage
`default_nettype wire

>>> rtl/enat_ram.sv
// Generic single-write, single-read memory with registered read data.
`default_nettype none
module enat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

>>> rtl/enat_cmp.sv
// Slot compare unit shared by every walk over the table.
`default_nettype none
module enat_cmp (
  input  enat_pkg::entry_t               entry,
  input  logic [enat_pkg::KEY_W-1:0]     key,
  input  logic [enat_pkg::TIME_W-1:0]    now,
  output enat_pkg::cmp_flags_t           flags
);
  import enat_pkg::*;

  // A slot matches only when it holds the key; it expires when now is past its expiry.
  always_comb begin
    flags.match   = entry.valid && (entry.key == key);
    flags.free    = !entry.valid;
    flags.expired = entry.valid && (now > entry.expiry);
  end

endmodule
`default_nettype wire

>>> rtl/expiring_node_address_table.sv
// Top level of the expiring node address table: sequencer, registers and table memory.
//
// Usage: items enter on in_valid/in_ready with payload in_data and leave on
// out_valid/out_ready with payload out_data; each item gives exactly one result.
// A put stores or refreshes a node address, a lookup reads it back, and a tick
// frees every slot whose expiry lies before now. Configuration is to be written
// through cfg_we/cfg_index/cfg_data while the block is idle; the block itself does
// not enforce this, and a written value applies to items accepted after the write.
// Every item walks the whole table through one memory read port, one slot per
// cycle, with one compare unit; a new item is accepted only once the previous
// result has been handed to the output register. The walk over the table memory's
// single read port sets how often items are taken. After reset the block clears
// the table one slot a cycle and holds in_ready low meanwhile; configuration
// writes are taken then. The result sits in an output register. While the receiver
// stalls, the block still takes one new item and works on it, and then waits until
// the output register is free before it hands over the next result.
`default_nettype none
module expiring_node_address_table #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  enat_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output enat_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [enat_pkg::CFG_IW-1:0]     cfg_index,
  input  logic [enat_pkg::CFG_DW-1:0]     cfg_data
);
  import enat_pkg::*;

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int EW = $bits(entry_t);
  localparam logic [IW:0] LAST_CNT  = (IW + 1)'(TABLE_ENTRIES);
  localparam logic [IW:0] CLEAR_END = (IW + 1)'(TABLE_ENTRIES - 1);

  // Sequencer states.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FIN   = 3'd3;

  logic [2:0]        state_r, state_nxt;
  logic [IW:0]       cnt_r, cnt_nxt;
  logic              pend_r, pend_nxt;
  logic [IW-1:0]     pend_idx_r, pend_idx_nxt;
  in_item_t          item_r, item_nxt;
  logic              self_r, self_nxt;
  logic [TIME_W-1:0] exp_r, exp_nxt;
  logic              hit_r, hit_nxt;
  logic [IW-1:0]     hit_idx_r, hit_idx_nxt;
  logic              free_r, free_nxt;
  logic [IW-1:0]     free_idx_r, free_idx_nxt;
  logic [63:0]       found_hi_r, found_hi_nxt;
  logic [63:0]       found_lo_r, found_lo_nxt;
  logic [15:0]       found_port_r, found_port_nxt;
  logic [CW-1:0]     rem_r, rem_nxt;
  logic [CW-1:0]     valid_cnt_r, valid_cnt_nxt;
  out_item_t         res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;
  logic [31:0]       own_top_r, own_top_nxt;
  logic [63:0]       own_mid_r, own_mid_nxt;
  logic [63:0]       own_low_r, own_low_nxt;
  logic [LIFE_W-1:0] life_r, life_nxt;

  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  entry_t            ram_wdata;
  logic [IW-1:0]     ram_raddr;
  logic [EW-1:0]     ram_rdata;
  entry_t            rd_entry;
  entry_t            new_entry;
  cmp_flags_t        flags;
  logic [TIME_W:0]   exp_sum;
  logic [CW-1:0]     occ_val;
  logic [CW+6:0]     occ_wide;
  logic [CW+6:0]     rem_wide;

  assign rd_entry = entry_t'(ram_rdata);

  // Table memory: one slot per word.
  enat_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Shared compare unit, fed by the slot read in the previous cycle.
  enat_cmp u_cmp (
    .entry (rd_entry),
    .key   ({item_r.key_top, item_r.key_mid, item_r.key_low}),
    .now   (item_r.now_seconds),
    .flags (flags)
  );

  // Expiry of a put saturates at the largest time value.
  assign exp_sum = {1'b0, in_data.now_seconds} + {{(TIME_W + 1 - LIFE_W){1'b0}}, life_r};

  // Slot written by a put.
  always_comb begin
    new_entry.valid        = 1'b1;
    new_entry.key          = {item_r.key_top, item_r.key_mid, item_r.key_low};
    new_entry.address_high = item_r.address_high;
    new_entry.address_low  = item_r.address_low;
    new_entry.port         = item_r.port_in;
    new_entry.expiry       = exp_r;
  end

  // Occupancy once the current item is done.
  always_comb begin
    occ_val = valid_cnt_r;
    if (item_r.kind == KIND_TICK) begin
      occ_val = valid_cnt_r - rem_r;
    end else if (item_r.kind == KIND_PUT && !self_r && !hit_r && free_r) begin
      occ_val = valid_cnt_r + CW'(1);
    end
  end

  // Counts are reported modulo 128.
  assign occ_wide = {7'd0, occ_val};
  assign rem_wide = {7'd0, rem_r};

  assign in_ready = (state_r == S_IDLE);

  // Sequencer and datapath next values.
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = pend_r;
    pend_idx_nxt   = pend_idx_r;
    item_nxt       = item_r;
    self_nxt       = self_r;
    exp_nxt        = exp_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    found_hi_nxt   = found_hi_r;
    found_lo_nxt   = found_lo_r;
    found_port_nxt = found_port_r;
    rem_nxt        = rem_r;
    valid_cnt_nxt  = valid_cnt_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    own_top_nxt    = own_top_r;
    own_mid_nxt    = own_mid_r;
    own_low_nxt    = own_low_r;
    life_nxt       = life_r;
    ram_we         = 1'b0;
    ram_waddr      = pend_idx_r;
    ram_wdata      = rd_entry;
    ram_raddr      = cnt_r[IW-1:0];

    // The receiver took the waiting result.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r[IW-1:0];
        ram_wdata = '0;
        if (cnt_r == CLEAR_END) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + (IW + 1)'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          cnt_nxt   = '0;
          pend_nxt  = 1'b0;
          hit_nxt   = 1'b0;
          free_nxt  = 1'b0;
          rem_nxt   = '0;
          exp_nxt   = exp_sum[TIME_W] ? '1 : exp_sum[TIME_W-1:0];
          self_nxt  = ({in_data.key_top, in_data.key_mid, in_data.key_low}
                       == {own_top_r, own_mid_r, own_low_r});
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // Issue the next slot read.
        if (cnt_r != LAST_CNT) begin
          cnt_nxt      = cnt_r + (IW + 1)'(1);
          pend_nxt     = 1'b1;
          pend_idx_nxt = cnt_r[IW-1:0];
        end else begin
          pend_nxt = 1'b0;
        end
        // Judge the slot that came back from the memory.
        if (pend_r) begin
          if (flags.match && !hit_r) begin
            hit_nxt        = 1'b1;
            hit_idx_nxt    = pend_idx_r;
            found_hi_nxt   = rd_entry.address_high;
            found_lo_nxt   = rd_entry.address_low;
            found_port_nxt = rd_entry.port;
          end
          if (flags.free && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = pend_idx_r;
          end
          if (item_r.kind == KIND_TICK && flags.expired) begin
            ram_we          = 1'b1;
            ram_wdata.valid = 1'b0;
            rem_nxt         = rem_r + CW'(1);
          end
        end
        // Walk finished: write a put that refreshes or takes a slot, and form the result.
        if (cnt_r == LAST_CNT && !pend_r) begin
          res_nxt           = '0;
          res_nxt.status    = ST_MISS;
          res_nxt.occupancy = occ_wide[6:0];
          case (item_r.kind)
            KIND_PUT: begin
              if (self_r) begin
                res_nxt.status = ST_SELF;
              end else if (hit_r) begin
                res_nxt.status = ST_REFRESH;
                ram_we         = 1'b1;
                ram_waddr      = hit_idx_r;
                ram_wdata      = new_entry;
              end else if (free_r) begin
                res_nxt.status = ST_NEW;
                ram_we         = 1'b1;
                ram_waddr      = free_idx_r;
                ram_wdata      = new_entry;
              end else begin
                res_nxt.status = ST_FULL;
              end
            end
            KIND_LOOKUP: begin
              if (hit_r) begin
                res_nxt.status             = ST_HIT;
                res_nxt.found_address_high = found_hi_r;
                res_nxt.found_address_low  = found_lo_r;
                res_nxt.found_port         = found_port_r;
              end
            end
            KIND_TICK: begin
              res_nxt.status        = ST_EXPIRED;
              res_nxt.removed_count = rem_wide[6:0];
            end
            default: begin
              res_nxt.status = ST_MISS;
            end
          endcase
          valid_cnt_nxt = occ_val;
          state_nxt     = S_FIN;
        end
      end
      S_FIN: begin
        // Hand the result over once the output register is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Configuration writes.
    if (cfg_we) begin
      case (cfg_index)
        REG_OWN_TOP:  own_top_nxt = cfg_data[31:0];
        REG_OWN_MID:  own_mid_nxt = cfg_data;
        REG_OWN_LOW:  own_low_nxt = cfg_data;
        REG_LIFETIME: life_nxt    = cfg_data[LIFE_W-1:0];
        default:      own_top_nxt = own_top_r;
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      rem_r       <= '0;
      valid_cnt_r <= '0;
      out_valid_r <= 1'b0;
      own_top_r   <= '0;
      own_mid_r   <= '0;
      own_low_r   <= '0;
      life_r      <= LIFETIME_RESET;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      hit_r       <= hit_nxt;
      free_r      <= free_nxt;
      rem_r       <= rem_nxt;
      valid_cnt_r <= valid_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      own_top_r   <= own_top_nxt;
      own_mid_r   <= own_mid_nxt;
      own_low_r   <= own_low_nxt;
      life_r      <= life_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pend_idx_r   <= pend_idx_nxt;
    item_r       <= item_nxt;
    self_r       <= self_nxt;
    exp_r        <= exp_nxt;
    hit_idx_r    <= hit_idx_nxt;
    free_idx_r   <= free_idx_nxt;
    found_hi_r   <= found_hi_nxt;
    found_lo_r   <= found_lo_nxt;
    found_port_r <= found_port_nxt;
    res_r        <= res_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // The count of valid slots never exceeds the table size.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_cnt_r <= CW'(TABLE_ENTRIES))
    else $error("valid slot count above table size");

  // A tick cannot free more slots than are occupied.
  a_removed_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (rem_r <= valid_cnt_r))
    else $error("removed count exceeds occupancy");

  // The table is written only while clearing or walking.
  a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLEAR || state_r == S_SCAN))
    else $error("table written outside a walk");

  // A result is loaded only from the finishing state.
  a_load_source: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && out_valid_nxt) |-> (state_r == S_FIN))
    else $error("result loaded outside the finishing state");
`endif

endmodule
`default_nettype wire
